@@ src/sfdb_pkg.sv @@
// ----------------------------------------------------------------------------
// sfdb_pkg: shared types and constants
// Frame geometry, sync code and the result record passed from the frame
// controller to the output register of the receiver.
// ----------------------------------------------------------------------------
package sfdb_pkg;

    // Data bytes stored per frame (sync byte excluded)
    localparam int unsigned FRAME_BYTES = 192;

    // Byte position counter: 0 waits for sync, 1..FRAME_BYTES next slot
    localparam int unsigned POS_W = $clog2(FRAME_BYTES + 1);

    // Frame buffer index width (fixed by the write_index field)
    localparam int unsigned IDX_W = 8;

    // Received data width
    localparam int unsigned DATA_W = 8;

    // Start-of-frame marker
    localparam logic [DATA_W-1:0] SYNC_BYTE = 8'hFF;

    // One result transaction
    typedef struct packed {
        logic              write_enable;
        logic              write_buffer;
        logic [IDX_W-1:0]  write_index;
        logic [DATA_W-1:0] write_data;
        logic              frame_done;
        logic              frame_dropped;
        logic              display_buffer;
    } t_result;

endpackage

@@ src/sfdb_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfdb_ctrl: frame controller
// Holds the byte position, fill buffer and pending error flag. Computes the
// result of one byte and updates the state when the byte advances.
// ----------------------------------------------------------------------------
module sfdb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [sfdb_pkg::DATA_W-1:0]  i_rx_byte,
    input  logic                         i_line_error,
    output sfdb_pkg::t_result            o_result
);

    logic [sfdb_pkg::POS_W-1:0] r_byte_position, n_byte_position;
    logic                       r_fill_buffer,   n_fill_buffer;
    logic                       r_error_pending, n_error_pending;

    // Next state and result for the byte at the controller input
    always_comb begin
        n_byte_position = r_byte_position;
        n_fill_buffer   = r_fill_buffer;
        n_error_pending = r_error_pending | i_line_error;

        o_result                = '0;
        o_result.write_buffer   = r_fill_buffer;

        if (r_byte_position == '0) begin
            // waiting for sync; anything else counts as an error
            if (i_rx_byte == sfdb_pkg::SYNC_BYTE) begin
                n_byte_position = sfdb_pkg::POS_W'(1);
            end else begin
                n_error_pending = 1'b1;
            end
        end else if (r_byte_position >= sfdb_pkg::POS_W'(sfdb_pkg::FRAME_BYTES)) begin
            // last byte: swap on a clean frame, drop otherwise
            o_result.write_enable = 1'b1;
            o_result.write_index  = sfdb_pkg::IDX_W'(sfdb_pkg::FRAME_BYTES - 1);
            o_result.write_data   = i_rx_byte;
            n_byte_position       = '0;
            if (n_error_pending) begin
                n_error_pending        = 1'b0;
                o_result.frame_dropped = 1'b1;
            end else begin
                n_fill_buffer       = ~r_fill_buffer;
                o_result.frame_done = 1'b1;
            end
        end else begin
            o_result.write_enable = 1'b1;
            o_result.write_index  = sfdb_pkg::IDX_W'(r_byte_position - sfdb_pkg::POS_W'(1));
            o_result.write_data   = i_rx_byte;
            n_byte_position       = r_byte_position + sfdb_pkg::POS_W'(1);
        end

        o_result.display_buffer = ~n_fill_buffer;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_fill_buffer   <= 1'b0;
            r_error_pending <= 1'b0;
        end else if (i_advance) begin
            r_byte_position <= n_byte_position;
            r_fill_buffer   <= n_fill_buffer;
            r_error_pending <= n_error_pending;
        end
    end

endmodule

@@ src/sync_framed_double_buffer_receiver_top.sv @@
// ----------------------------------------------------------------------------
// sync_framed_double_buffer_receiver_top: sync-framed byte receiver
// Waits for the sync byte, then writes each frame's data bytes into one of
// two frame buffers through a write port, swapping on clean frames.
//
//   channel | handshake          | payload
//   --------+--------------------+----------------------------------------
//   input   | i_valid / o_stall  | i_rx_byte, i_line_error
//   result  | o_valid / i_stall  | o_write_enable .. o_display_buffer
//
// One byte per cycle sustained while the result channel is not stalled; each
// byte passes the input register, then the result register after the controller update.
// Reset is synchronous: waiting for sync, first buffer filling, no error.
// A stalled result holds the result register; the input register keeps its
// byte and o_stall rises only while both registers are full.
// ----------------------------------------------------------------------------
module sync_framed_double_buffer_receiver_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sfdb_pkg::DATA_W-1:0]  i_rx_byte,
    input  logic                         i_line_error,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_write_enable,
    output logic                         o_write_buffer,
    output logic [sfdb_pkg::IDX_W-1:0]   o_write_index,
    output logic [sfdb_pkg::DATA_W-1:0]  o_write_data,
    output logic                         o_frame_done,
    output logic                         o_frame_dropped,
    output logic                         o_display_buffer
);

    logic                        r_in_valid;
    logic [sfdb_pkg::DATA_W-1:0] r_in_byte;
    logic                        r_in_error;
    logic                        r_out_valid;
    sfdb_pkg::t_result           r_out;
    sfdb_pkg::t_result           ctrl_result;
    logic                        out_hold;
    logic                        advance;
    logic                        in_fire;

    // Pipeline flow control
    assign out_hold = r_out_valid & i_stall;
    assign advance  = r_in_valid & ~out_hold;
    assign o_stall  = r_in_valid & out_hold;
    assign in_fire  = i_valid & ~o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_rx_byte;
            r_in_error <= i_line_error;
        end
    end

    // Frame controller
    sfdb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_rx_byte    (r_in_byte),
        .i_line_error (r_in_error),
        .o_result     (ctrl_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_hold) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= ctrl_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_write_enable   = r_out.write_enable;
    assign o_write_buffer   = r_out.write_buffer;
    assign o_write_index    = r_out.write_index;
    assign o_write_data     = r_out.write_data;
    assign o_frame_done     = r_out.frame_done;
    assign o_frame_dropped  = r_out.frame_dropped;
    assign o_display_buffer = r_out.display_buffer;

endmodule
